### design/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, token codes and keyword helpers for the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

    // Largest text the offset counters are sized for
    localparam longint unsigned TEXT_BYTES = 64'd65536;

    // Offsets stop at the smaller of the text bound and the field range
    localparam logic [15:0] OFFSET_LIMIT =
        (TEXT_BYTES < 64'd65535) ? 16'(TEXT_BYTES) : 16'hFFFF;

    // Token kinds
    localparam logic [3:0] KIND_LBRACE  = 4'd0;
    localparam logic [3:0] KIND_RBRACE  = 4'd1;
    localparam logic [3:0] KIND_LSQUARE = 4'd2;
    localparam logic [3:0] KIND_RSQUARE = 4'd3;
    localparam logic [3:0] KIND_COMMA   = 4'd4;
    localparam logic [3:0] KIND_COLON   = 4'd5;
    localparam logic [3:0] KIND_TRUE    = 4'd6;
    localparam logic [3:0] KIND_FALSE   = 4'd7;
    localparam logic [3:0] KIND_NULL    = 4'd8;
    localparam logic [3:0] KIND_STRING  = 4'd9;
    localparam logic [3:0] KIND_INT     = 4'd10;
    localparam logic [3:0] KIND_FLOAT   = 4'd11;
    localparam logic [3:0] KIND_UNKNOWN = 4'd12;
    localparam logic [3:0] KIND_END     = 4'd13;

    // Keyword selectors
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_MINUS     = 8'h2D;

    // One token of the result buffer
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Letter expected at a position of a keyword
    function automatic logic [7:0] kw_letter(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            KW_TRUE:
            begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_FALSE:
            begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_NULL:
            begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Keyword length in bytes
    function automatic logic [2:0] kw_len(input logic [1:0] sel);
        logic [2:0] len;
        case (sel)
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            KW_NULL:  len = 3'd4;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    // Clamp a grown length to the field range
    function automatic logic [15:0] sat_len(input logic [16:0] len);
        return len[16] ? 16'hFFFF : len[15:0];
    endfunction

endpackage

### design/json_token_scanner_top.sv
// ----------------------------------------------------------------------------
// json_token_scanner_top
// Streaming JSON lexer: one text byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// The scanner takes one byte of JSON text per cycle while its input is ready
// and reports each token with its kind, start offset and length. A byte is
// scanned in the cycle it is accepted: the scanner state updates at once and
// its tokens land in a three-entry result buffer that drains one token per
// cycle while the token channel is ready, the first showing in the cycle after
// its byte. Text whose bytes cause at most one token each streams at one byte
// per cycle while the tokens are taken; a byte that causes more (up to three,
// at the final byte or where a number is ended by a byte that is itself a
// token) holds the input while the buffer drains. The input is ready when the
// buffer is empty or is handing out its last token. After the final byte the
// scanner is reset again and the next byte starts a new text at offset zero.
module json_token_scanner_top
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_KEYWORD,
        MODE_STRING,
        MODE_NUMBER,
        MODE_SKIP
    } mode_t;

    // Scanner state
    mode_t       mode_reg, mode_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] begin_reg, begin_next;
    logic [1:0]  sel_reg, sel_next;
    logic [2:0]  pos_reg, pos_next;
    logic        dot_reg, dot_next;
    logic        parity_reg, parity_next;

    // Result buffer
    token_t      slot_reg [3];
    token_t      slot_next [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  rd_reg;

    logic        text_fire;
    logic        token_fire;

    assign token_fire  = token_valid && token_ready;
    assign text_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && token_ready);
    assign text_fire   = text_valid && text_ready;

    assign token_valid  = (cnt_reg != 2'd0);
    assign token_kind   = slot_reg[rd_reg].kind;
    assign token_start  = slot_reg[rd_reg].start;
    assign token_length = slot_reg[rd_reg].length;
    assign last_of_run  = slot_reg[rd_reg].last;

    // Scan one byte: next state and the tokens it causes
    always_comb
    begin
        logic [7:0]  c;
        logic [15:0] p;
        logic        is_digit;
        logic        run_idle;
        logic [2:0]  klen;
        logic [2:0]  pos_inc;
        logic [16:0] span;

        c        = text_byte;
        p        = offset_reg;
        is_digit = (c >= "0") && (c <= "9");
        run_idle = 1'b0;
        klen     = kw_len(sel_reg);
        pos_inc  = pos_reg + 3'd1;
        span     = {1'b0, p} - {1'b0, begin_reg} + 17'd1;

        mode_next   = mode_reg;
        begin_next  = begin_reg;
        sel_next    = sel_reg;
        pos_next    = pos_reg;
        dot_next    = dot_reg;
        parity_next = parity_reg;
        cnt_next    = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = '0;
        end

        // Continue the token in progress
        case (mode_reg)
            MODE_IDLE:
            begin
                run_idle = 1'b1;
            end
            MODE_KEYWORD:
            begin
                if ((sel_reg != 2'd3) && (pos_reg < klen) && (c == kw_letter(sel_reg, pos_reg)))
                begin
                    pos_next = pos_inc;
                    if (pos_inc == klen)
                    begin
                        slot_next[cnt_next] = '{KIND_TRUE + 4'(sel_reg), begin_reg,
                                                16'(klen), 1'b0};
                        cnt_next  = cnt_next + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                else
                begin
                    slot_next[cnt_next] = '{KIND_UNKNOWN, begin_reg, sat_len(span), 1'b0};
                    cnt_next  = cnt_next + 2'd1;
                    mode_next = MODE_SKIP;
                end
            end
            MODE_STRING:
            begin
                if ((c == CH_QUOTE) && !parity_reg)
                begin
                    slot_next[cnt_next] = '{KIND_STRING, begin_reg, sat_len(span), 1'b0};
                    cnt_next  = cnt_next + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    parity_next = (c == CH_BACKSLASH) ? !parity_reg : 1'b0;
                end
            end
            MODE_NUMBER:
            begin
                if ((c == CH_DOT) && !dot_reg)
                begin
                    dot_next = 1'b1;
                end
                else if (!is_digit)
                begin
                    slot_next[cnt_next] = '{dot_reg ? KIND_FLOAT : KIND_INT, begin_reg,
                                            p - begin_reg, 1'b0};
                    cnt_next  = cnt_next + 2'd1;
                    mode_next = MODE_IDLE;
                    run_idle  = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_SKIP;
            end
        endcase

        // Scan the byte as the start of a new token
        if (run_idle)
        begin
            case (c)
                "{", "}", "[", "]", ",", ":":
                begin
                    slot_next[cnt_next].kind   = (c == "{") ? KIND_LBRACE  :
                                                 (c == "}") ? KIND_RBRACE  :
                                                 (c == "[") ? KIND_LSQUARE :
                                                 (c == "]") ? KIND_RSQUARE :
                                                 (c == ",") ? KIND_COMMA   : KIND_COLON;
                    slot_next[cnt_next].start  = p;
                    slot_next[cnt_next].length = 16'd1;
                    cnt_next = cnt_next + 2'd1;
                end
                8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D:
                begin
                    mode_next = mode_next;
                end
                "t", "f", "n":
                begin
                    mode_next  = MODE_KEYWORD;
                    sel_next   = (c == "t") ? KW_TRUE : (c == "f") ? KW_FALSE : KW_NULL;
                    pos_next   = 3'd1;
                    begin_next = p;
                end
                CH_QUOTE:
                begin
                    mode_next   = MODE_STRING;
                    parity_next = 1'b0;
                    begin_next  = p;
                end
                default:
                begin
                    if (((c == CH_MINUS) && !final_byte) || is_digit)
                    begin
                        mode_next  = MODE_NUMBER;
                        dot_next   = 1'b0;
                        begin_next = p;
                    end
                    else
                    begin
                        slot_next[cnt_next] = '{KIND_UNKNOWN, p, 16'd1, 1'b0};
                        cnt_next  = cnt_next + 2'd1;
                        mode_next = MODE_SKIP;
                    end
                end
            endcase
        end

        // Advance the offset, holding at the limit
        offset_next = (offset_reg < OFFSET_LIMIT) ? offset_reg + 16'd1 : OFFSET_LIMIT;

        // Flush the open token, close the text and return to reset
        if (final_byte)
        begin
            span = {1'b0, p} - {1'b0, begin_next} + 17'd1;
            if (mode_next == MODE_NUMBER)
            begin
                slot_next[cnt_next] = '{dot_next ? KIND_FLOAT : KIND_INT, begin_next,
                                        sat_len(span), 1'b0};
                cnt_next = cnt_next + 2'd1;
            end
            else if ((mode_next == MODE_KEYWORD) || (mode_next == MODE_STRING))
            begin
                slot_next[cnt_next] = '{KIND_UNKNOWN, begin_next, sat_len(span), 1'b0};
                cnt_next = cnt_next + 2'd1;
            end
            slot_next[cnt_next] = '{KIND_END, offset_next, 16'd0, 1'b0};
            cnt_next = cnt_next + 2'd1;

            mode_next   = MODE_IDLE;
            offset_next = 16'd0;
            begin_next  = 16'd0;
            sel_next    = 2'd0;
            pos_next    = 3'd0;
            dot_next    = 1'b0;
            parity_next = 1'b0;
        end

        // Mark the last token of this byte
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i].last = (cnt_next != 2'd0) && (2'(i) == cnt_next - 2'd1);
        end
    end

    // Hold scanner state and buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= 16'd0;
            begin_reg  <= 16'd0;
            sel_reg    <= 2'd0;
            pos_reg    <= 3'd0;
            dot_reg    <= 1'b0;
            parity_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            rd_reg     <= 2'd0;
        end
        else if (text_fire)
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            begin_reg  <= begin_next;
            sel_reg    <= sel_next;
            pos_reg    <= pos_next;
            dot_reg    <= dot_next;
            parity_reg <= parity_next;
            cnt_reg    <= cnt_next;
            rd_reg     <= 2'd0;
        end
        else if (token_fire)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    // Load the result buffer on each input transaction
    always_ff @(posedge clk)
    begin
        if (text_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

### design/jts_checker.sv
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks on the token channel of the JSON token scanner.
// ----------------------------------------------------------------------------
module jts_checker
    import jts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        text_ready,
    input logic        token_valid,
    input logic        token_ready,
    input logic [3:0]  token_kind,
    input logic [15:0] token_start,
    input logic [15:0] token_length,
    input logic        last_of_run
);

    // Hold a stalled token transaction
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token_kind)
        && $stable(token_start) && $stable(token_length))
        else $error("token transaction dropped or changed while stalled");

    // End of text closes the run with zero length
    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind == KIND_END) |-> (token_length == 16'd0) && last_of_run)
        else $error("end token malformed");

    // Punctuation is one byte
    a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind <= KIND_COLON) |-> (token_length == 16'd1))
        else $error("punctuation token length not one");

    // Input waits while more than one token is queued
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !last_of_run |-> !text_ready)
        else $error("input taken while tokens of a byte are still queued");

endmodule

bind json_token_scanner_top jts_checker u_jts_checker (.*);

### verif/json_token_scanner_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_token_scanner_top_tb
// Self-checking bench for the streaming JSON token scanner.
// ----------------------------------------------------------------------------
// Streams JSON text into the byte channel and predicts every token with a
// behavioral scanner kept inside the bench. A monitor compares each token
// transaction, field by field, with the oldest prediction. Directed texts
// cover each token kind and the error paths. Random texts, built mostly from
// well-formed fragments with some noise and broken keywords, fill the rest.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module json_token_scanner_top_tb;
    import jts_pkg::*;

    localparam int IDLE_MAX      = 12;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_BYTES  = 280;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_MAX     = 50;

    typedef enum logic [2:0]
    {
        LEX_IDLE,
        LEX_KEYWORD,
        LEX_STRING,
        LEX_NUMBER,
        LEX_SKIP
    } lex_mode_e;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        text_valid  = 1'b0;
    logic        text_ready;
    logic [7:0]  text_byte   = 8'h00;
    logic        final_byte  = 1'b0;
    logic        token_valid;
    logic        token_ready = 1'b0;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    // Scanner state of the predictor
    lex_mode_e   lex_mode   = LEX_IDLE;
    logic [15:0] text_pos   = 16'd0;
    logic [15:0] tok_begin  = 16'd0;
    int          kw_index   = 0;
    int          kw_pos     = 0;
    bit          dot_seen   = 1'b0;
    bit          escape_odd = 1'b0;

    string       kw_word [3] = '{"true", "false", "null"};
    logic [3:0]  kw_kind [3] = '{KIND_TRUE, KIND_FALSE, KIND_NULL};

    token_t      run_tokens[$];
    token_t      expected_tokens[$];

    bit          idle_on        = 1'b1;
    int          scanned_bytes  = 0;
    int          tokens_checked = 0;
    int          mismatches     = 0;
    int          idle_cycles    = 0;

    json_token_scanner_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Queue one predicted token of the current byte, clamping the length
    function automatic void push_token(input logic [3:0] kind, input logic [15:0] start,
                                       input int unsigned len);
        token_t tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = (len > 32'd65535) ? 16'hFFFF : 16'(len);
        tok.last   = 1'b0;
        run_tokens.push_back(tok);
    endfunction

    // Report an error token and ignore the rest of the text
    function automatic void push_unknown(input logic [15:0] start, input int unsigned len);
        push_token(KIND_UNKNOWN, start, len);
        lex_mode = LEX_SKIP;
    endfunction

    // Scan a byte seen between tokens
    function automatic void scan_token_start(input logic [7:0] c, input int unsigned pos,
                                             input logic is_final);
        case (c)
            "{": push_token(KIND_LBRACE, 16'(pos), 1);
            "}": push_token(KIND_RBRACE, 16'(pos), 1);
            "[": push_token(KIND_LSQUARE, 16'(pos), 1);
            "]": push_token(KIND_RSQUARE, 16'(pos), 1);
            ",": push_token(KIND_COMMA, 16'(pos), 1);
            ":": push_token(KIND_COLON, 16'(pos), 1);
            " ", "\t", "\n", "\v", "\f", "\r":
            begin
            end
            "t", "f", "n":
            begin
                lex_mode  = LEX_KEYWORD;
                kw_index  = (c == "t") ? 0 : (c == "f") ? 1 : 2;
                kw_pos    = 1;
                tok_begin = 16'(pos);
            end
            CH_QUOTE:
            begin
                lex_mode   = LEX_STRING;
                escape_odd = 1'b0;
                tok_begin  = 16'(pos);
            end
            default:
            begin
                // a minus that ends the text cannot become a number
                if (c == CH_MINUS && is_final)
                    push_unknown(16'(pos), 1);
                else if (c == CH_MINUS || (c >= "0" && c <= "9"))
                begin
                    lex_mode  = LEX_NUMBER;
                    dot_seen  = 1'b0;
                    tok_begin = 16'(pos);
                end
                else
                    push_unknown(16'(pos), 1);
            end
        endcase
    endfunction

    // Advance the predictor by one accepted byte and queue its tokens
    function automatic void predict_tokens(input logic [7:0] c, input logic is_final);
        int unsigned pos;
        string       word;
        pos = text_pos;
        run_tokens.delete();
        case (lex_mode)
            LEX_IDLE:
                scan_token_start(c, pos, is_final);
            LEX_KEYWORD:
            begin
                word = kw_word[kw_index];
                if (kw_pos < word.len() && c == word[kw_pos])
                begin
                    kw_pos++;
                    if (kw_pos == word.len())
                    begin
                        push_token(kw_kind[kw_index], tok_begin, kw_pos);
                        lex_mode = LEX_IDLE;
                    end
                end
                else
                    push_unknown(tok_begin, pos - tok_begin + 1);
            end
            LEX_STRING:
            begin
                // a quote closes only after an even run of backslashes
                if (c == CH_QUOTE && !escape_odd)
                begin
                    push_token(KIND_STRING, tok_begin, pos - tok_begin + 1);
                    lex_mode = LEX_IDLE;
                end
                else
                    escape_odd = (c == CH_BACKSLASH) ? !escape_odd : 1'b0;
            end
            LEX_NUMBER:
            begin
                if (c == CH_DOT && !dot_seen)
                    dot_seen = 1'b1;
                else if (!(c >= "0" && c <= "9"))
                begin
                    // close the number and rescan the byte as a token start
                    push_token(dot_seen ? KIND_FLOAT : KIND_INT, tok_begin, pos - tok_begin);
                    lex_mode = LEX_IDLE;
                    scan_token_start(c, pos, is_final);
                end
            end
            default:
            begin
            end
        endcase

        if (text_pos < OFFSET_LIMIT)
            text_pos = text_pos + 16'd1;

        // flush the open token, close the text and start over
        if (is_final)
        begin
            if (lex_mode == LEX_NUMBER)
                push_token(dot_seen ? KIND_FLOAT : KIND_INT, tok_begin, pos - tok_begin + 1);
            else if (lex_mode == LEX_KEYWORD || lex_mode == LEX_STRING)
                push_token(KIND_UNKNOWN, tok_begin, pos - tok_begin + 1);
            push_token(KIND_END, text_pos, 0);
            lex_mode   = LEX_IDLE;
            text_pos   = 16'd0;
            tok_begin  = 16'd0;
            kw_index   = 0;
            kw_pos     = 0;
            dot_seen   = 1'b0;
            escape_odd = 1'b0;
        end

        if (run_tokens.size() > 0)
            run_tokens[run_tokens.size() - 1].last = 1'b1;
        foreach (run_tokens[i])
            expected_tokens.push_back(run_tokens[i]);
    endfunction

    // Print the first few mismatches, count all of them
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_MAX)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Send one byte transaction after a random gap
    task automatic send_byte(input logic [7:0] value, input logic is_final);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= value;
        final_byte <= is_final;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
    endtask

    // Send a text, marking its last byte as final
    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], i == text.len() - 1);
    endtask

    // Predict on every accepted byte, check every accepted token
    always @(posedge clk)
    begin : monitor
        token_t want;
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                if (lex_mode != LEX_SKIP)
                    scanned_bytes++;
                predict_tokens(text_byte, final_byte);
            end
            if (token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("token kind %0d start %0d with none expected",
                                              token_kind, token_start));
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                        report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                                  tokens_checked, token_kind, want.kind));
                    if (token_start !== want.start)
                        report_mismatch($sformatf("token %0d start %0d, expected %0d",
                                                  tokens_checked, token_start, want.start));
                    if (token_length !== want.length)
                        report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                                  tokens_checked, token_length, want.length));
                    if (last_of_run !== want.last)
                        report_mismatch($sformatf("token %0d last_of_run %0b, expected %0b",
                                                  tokens_checked, last_of_run, want.last));
                end
                tokens_checked++;
            end
        end
    end

    // Stall the token channel for a random count before each transaction
    always
    begin : token_sink
        int stall;
        stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (stall > 0)
        begin
            token_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        token_ready <= 1'b1;
        @(posedge clk);
        while (!(token_valid && token_ready))
            @(posedge clk);
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin : watchdog
        if ((text_valid && text_ready) || (token_valid && token_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Punctuation between whitespace; the text ends in whitespace
    task automatic test_punctuation();
        idle_on = 1'b1;
        send_text("{ }\t[\n]\v,\f:\r");
    endtask

    // Whole keywords, a misspelled one and one cut off by the end of text
    task automatic test_keywords();
        send_text("true,false:null");
        send_text("trUe]");
        send_text("nul");
    endtask

    // Escaped quotes, an unterminated string and a lone quote
    task automatic test_strings();
        send_text("\"a\\\"b\\\\\"");
        send_text("\"ab");
        send_text("\"");
    endtask

    // Float ended by punctuation, bare minus, second dot, minus at the end, lone digit
    task automatic test_numbers();
        send_text("-12.5}");
        send_text("7 -x");
        send_text("1.2.3");
        send_text("-");
        send_text("0");
    endtask

    // Stray bytes at both ends of the byte range
    task automatic test_stray_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Random texts from well-formed fragments mixed with noise
    task automatic test_random_texts();
        logic [7:0] text_buf[$];
        string      punct_marks = "{}[],:";
        string      blanks      = " \t\n\v\f\r";
        string      word;
        int         frags;
        int         pick;
        int         n;
        int         goal;
        goal = scanned_bytes + RANDOM_BYTES;
        while (scanned_bytes < goal)
        begin
            text_buf.delete();
            idle_on = ($urandom_range(0, 3) != 0);
            frags = $urandom_range(1, 6);
            repeat (frags)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    text_buf.push_back(punct_marks[$urandom_range(0, 5)]);
                else if (pick < 45)
                begin
                    word = kw_word[$urandom_range(0, 2)];
                    for (int i = 0; i < word.len(); i++)
                        text_buf.push_back(word[i]);
                end
                else if (pick < 62)
                begin
                    // string with printable text, backslashes and raw bytes
                    text_buf.push_back(CH_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 5)
                            text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        else if (pick < 8)
                            text_buf.push_back(CH_BACKSLASH);
                        else
                            text_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    text_buf.push_back(CH_QUOTE);
                end
                else if (pick < 80)
                begin
                    if ($urandom_range(0, 2) == 0)
                        text_buf.push_back(CH_MINUS);
                    n = $urandom_range(1, 4);
                    repeat (n) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
                    if ($urandom_range(0, 2) == 0)
                    begin
                        text_buf.push_back(CH_DOT);
                        n = $urandom_range(0, 3);
                        repeat (n) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
                    end
                end
                else if (pick < 90)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) text_buf.push_back(blanks[$urandom_range(0, 5)]);
                end
                else if (pick < 95)
                begin
                    // keyword cut short and followed by an arbitrary byte
                    word = kw_word[$urandom_range(0, 2)];
                    n = $urandom_range(1, word.len() - 1);
                    for (int i = 0; i < n; i++)
                        text_buf.push_back(word[i]);
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end
                else
                    text_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                    text_buf.push_back(" ");
            end
            for (int i = 0; i < text_buf.size(); i++)
                send_byte(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_punctuation();
        test_keywords();
        test_strings();
        test_numbers();
        test_stray_bytes();
        test_random_texts();

        // drain outstanding tokens, then watch for strays
        text_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### json_token_scanner_top.f
design/jts_pkg.sv
design/json_token_scanner_top.sv
design/jts_checker.sv
verif/json_token_scanner_top_tb.sv
